/* src/dpmc_pkg.sv */
// Package for the dead pixel median correction block.
// Holds register indexes, request codes and fixed widths; no dependencies.
`default_nettype none

package dpmc_pkg;

  // Configuration port geometry
  localparam int CFG_W     = 13;
  localparam int DEPTH_W   = 5;
  localparam int REG_IDX_W = 2;

  // Smallest usable frame dimension
  localparam int DIM_MIN = 3;

  // Neighbour count of a 3x3 window and width of a count over it
  localparam int NB_COUNT = 8;
  localparam int NB_CNT_W = 4;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BIT_DEPTH    = 2'd2,
    REG_ENABLE       = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_t;

  // Register values after reset
  localparam logic [CFG_W-1:0]   RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0]   RST_FRAME_HEIGHT = 13'd480;
  localparam logic [DEPTH_W-1:0] RST_BIT_DEPTH    = 5'd12;
  localparam logic               RST_ENABLE       = 1'b1;

endpackage

`default_nettype wire

/* src/dpmc_median.sv */
// Upper median of the live neighbours of a 3x3 window.
// Rank-based selection, purely combinational; uses dpmc_pkg.
`default_nettype none

module dpmc_median
  import dpmc_pkg::*;
#(
  parameter int PIXEL_BITS = 16
) (
  input  logic [NB_COUNT-1:0][PIXEL_BITS-1:0] nb,
  input  logic [PIXEL_BITS-1:0]               stuck,
  output logic [PIXEL_BITS-1:0]               med,
  output logic                                found
);

  logic [NB_COUNT-1:0] live;
  logic [NB_CNT_W-1:0] n_live;
  logic [NB_CNT_W-1:0] target;
  logic [NB_CNT_W-1:0] rank [NB_COUNT];

  always_comb begin
    // a neighbour counts only when it is not dead itself
    for (int i = 0; i < NB_COUNT; i++) begin
      live[i] = (nb[i] != '0) && (nb[i] != stuck);
    end

    n_live = '0;
    for (int i = 0; i < NB_COUNT; i++) begin
      n_live = n_live + NB_CNT_W'(live[i]);
    end
    target = n_live >> 1;

    // rank = sorted position, ties broken by window position
    for (int i = 0; i < NB_COUNT; i++) begin
      rank[i] = '0;
      for (int j = 0; j < NB_COUNT; j++) begin
        if (j != i && live[j] && ((nb[j] < nb[i]) || ((nb[j] == nb[i]) && (j < i)))) begin
          rank[i] = rank[i] + NB_CNT_W'(1);
        end
      end
    end

    // live ranks form a permutation, so exactly one entry matches
    med = '0;
    for (int i = 0; i < NB_COUNT; i++) begin
      if (live[i] && (rank[i] == target)) begin
        med = med | nb[i];
      end
    end

    found = (n_live != '0);
  end

endmodule

`default_nettype wire

/* src/dead_pixel_median_correction.sv */
// Top level of the dead pixel median correction block.
// Depends on dpmc_pkg and dpmc_median.
//
// Usage:
//   Pixels enter in raster order on the in_ channel (valid/stall), one beat
//   per pixel; a beat with in_req_type = drain carries no pixel and pushes out
//   one pending pixel, if any. Results leave on the out_ channel in raster order.
//   A pixel's result is caused by the beat frame_width+1 pixels later, so the
//   last frame_width+1 pixels of a stream need drain beats to come out.
//   From the accepting edge of the causing beat, the result passes the line store read
//   and then the result register before out_valid rises. One beat per cycle is sustained
//   in both directions while out_stall is low; the 3x3 median is a single compare network.
//   A pixel that is 0 or 2^bit_depth-1 on an interior position is replaced by the upper
//   median of its live neighbours when enable is set and at least one neighbour is live.
//   Reset (rst_n low, synchronous) restores the register defaults
//   (640 x 480, 12 bits, enabled), clears the position counters, the pending
//   count and the window. Line stores are not cleared: an entry is always
//   written before it reaches a result. No clearing pass is needed.
//   When out_stall is high with a result waiting, the result holds and
//   in_stall rises in the same cycle; nothing is lost or repeated.
//   Configuration writes are taken at any edge with cfg_wr_en high; write
//   only while the stream is idle.
`default_nettype none

module dead_pixel_median_correction
  import dpmc_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration port
  input  logic                  cfg_wr_en,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [PIXEL_BITS-1:0] in_pixel_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_BITS-1:0] out_pixel_out,
  output logic                  out_replaced,
  output logic                  out_frame_end
);

  localparam int XW = $clog2(MAX_WIDTH);     // column index
  localparam int PW = $clog2(MAX_WIDTH + 2); // width and pending count
  localparam int CW = (PW > CFG_W) ? PW : CFG_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0]   cfg_fw_r;
  logic [CFG_W-1:0]   cfg_fh_r;
  logic [DEPTH_W-1:0] cfg_bd_r;
  logic               cfg_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_fw_r <= RST_FRAME_WIDTH;
      cfg_fh_r <= RST_FRAME_HEIGHT;
      cfg_bd_r <= RST_BIT_DEPTH;
      cfg_en_r <= RST_ENABLE;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  cfg_fw_r <= cfg_wr_data;
        REG_FRAME_HEIGHT: cfg_fh_r <= cfg_wr_data;
        REG_BIT_DEPTH:    cfg_bd_r <= cfg_wr_data[DEPTH_W-1:0];
        REG_ENABLE:       cfg_en_r <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // Effective geometry: clamp width to [3, MAX_WIDTH], height to >= 3
  logic [CW-1:0]         fw_ext;
  logic [CW-1:0]         fw_clamp;
  logic [PW-1:0]         eff_w;
  logic [PW-1:0]         w_last;
  logic [PW-1:0]         full;
  logic [CFG_W-1:0]      eff_h;
  logic [CFG_W-1:0]      h_last;
  logic [PIXEL_BITS-1:0] stuck;

  always_comb begin
    fw_ext = CW'(cfg_fw_r);
    if (fw_ext < CW'(DIM_MIN)) begin
      fw_clamp = CW'(DIM_MIN);
    end else if (fw_ext > CW'(MAX_WIDTH)) begin
      fw_clamp = CW'(MAX_WIDTH);
    end else begin
      fw_clamp = fw_ext;
    end
    eff_w  = PW'(fw_clamp);
    w_last = eff_w - PW'(1);
    full   = eff_w + PW'(1);
    eff_h  = (cfg_fh_r < CFG_W'(DIM_MIN)) ? CFG_W'(DIM_MIN) : cfg_fh_r;
    h_last = eff_h - CFG_W'(1);
    // stuck-high code: bit_depth ones, at least one, at most PIXEL_BITS
    for (int i = 0; i < PIXEL_BITS; i++) begin
      stuck[i] = (i == 0) || (DEPTH_W'(i) < cfg_bd_r);
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and stage control
  // ---------------------------------------------------------------------
  logic out_valid_r;
  logic s1_valid_r;
  logic adv;
  logic accept;
  logic s1_leave;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign s1_leave = s1_valid_r && adv;

  // ---------------------------------------------------------------------
  // Stage 0: position counters, pending count, line store addressing
  // ---------------------------------------------------------------------
  logic [XW-1:0]    in_col_r;
  logic [CFG_W-1:0] in_row_r;
  logic [XW-1:0]    out_col_r;
  logic [CFG_W-1:0] out_row_r;
  logic [PW-1:0]    pend_r;

  logic             s0_drain;
  logic             s0_take;
  logic             s0_emit;
  logic             s0_inner;
  logic             s0_fend;
  logic             s0_selup;
  logic [XW-1:0]    ic;
  logic [CFG_W-1:0] ir;
  logic [XW-1:0]    oc;
  logic [CFG_W-1:0] orow;
  logic [XW-1:0]    rd_addr;
  logic             pend_full;
  logic [PW-1:0]    pend_nxt;
  logic [XW-1:0]    in_col_nxt;
  logic [CFG_W-1:0] in_row_nxt;
  logic [XW-1:0]    out_col_nxt;
  logic [CFG_W-1:0] out_row_nxt;

  always_comb begin
    s0_drain = (req_t'(in_req_type) == REQ_DRAIN);

    // restart any counter that lies beyond the current geometry
    ic   = (PW'(in_col_r) >= eff_w) ? '0 : in_col_r;
    ir   = (in_row_r >= eff_h) ? '0 : in_row_r;
    oc   = (PW'(out_col_r) >= eff_w) ? '0 : out_col_r;
    orow = (out_row_r >= eff_h) ? '0 : out_row_r;

    pend_full = (pend_r >= full);

    // advance the input position
    if (PW'(ic) == w_last) begin
      in_col_nxt = '0;
      in_row_nxt = (ir == h_last) ? '0 : ir + CFG_W'(1);
    end else begin
      in_col_nxt = ic + XW'(1);
      in_row_nxt = ir;
    end

    // advance the output position
    if (PW'(oc) == w_last) begin
      out_col_nxt = '0;
      out_row_nxt = (orow == h_last) ? '0 : orow + CFG_W'(1);
    end else begin
      out_col_nxt = oc + XW'(1);
      out_row_nxt = orow;
    end

    s0_fend  = (PW'(oc) == w_last) && (orow == h_last);
    s0_inner = cfg_en_r && (oc != '0) && (PW'(oc) != w_last) &&
               (orow != '0) && (orow != h_last);
    s0_selup = pend_full;

    if (s0_drain) begin
      // drain: send the oldest pending pixel unchanged
      s0_take  = (pend_r != '0);
      s0_emit  = s0_take;
      rd_addr  = oc;
      pend_nxt = s0_take ? ((pend_full ? full : pend_r) - PW'(1)) : pend_r;
    end else begin
      s0_take  = 1'b1;
      s0_emit  = pend_full;
      rd_addr  = ic;
      pend_nxt = pend_full ? full : pend_r + PW'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Line stores: middle written when a pixel beat is accepted, upper written
  // as the pixel leaves stage 1 (it needs the old middle entry)
  // ---------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] upper_mem  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] up_q;
  logic [PIXEL_BITS-1:0] mid_q;

  logic                  s1_drain_r;
  logic                  s1_emit_r;
  logic                  s1_inner_r;
  logic                  s1_fend_r;
  logic                  s1_selup_r;
  logic [XW-1:0]         s1_col_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic                  byp_r;
  logic [PIXEL_BITS-1:0] byp_data_r;

  logic rd_en;
  logic mid_we;
  logic up_we;

  assign rd_en  = accept && s0_take;
  assign mid_we = accept && !s0_drain;
  assign up_we  = s1_leave && !s1_drain_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q  <= upper_mem[rd_addr];
      mid_q <= middle_mem[rd_addr];
    end
    if (mid_we) begin
      middle_mem[ic] <= in_pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (up_we) begin
      upper_mem[s1_col_r] <= mid_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1 payload; forward the upper write that lands on the same edge
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_drain_r <= s0_drain;
      s1_emit_r  <= s0_emit;
      s1_inner_r <= s0_inner;
      s1_fend_r  <= s0_fend;
      s1_selup_r <= s0_selup;
      s1_col_r   <= rd_addr;
      s1_pix_r   <= in_pixel_in;
      byp_r      <= up_we && (s1_col_r == rd_addr);
      byp_data_r <= mid_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: window shift and correction
  // ---------------------------------------------------------------------
  logic [8:0][PIXEL_BITS-1:0]          win_r;
  logic [8:0][PIXEL_BITS-1:0]          win_nxt;
  logic [NB_COUNT-1:0][PIXEL_BITS-1:0] nb;
  logic [PIXEL_BITS-1:0]               up_val;
  logic [PIXEL_BITS-1:0]               centre;
  logic                                centre_dead;
  logic [PIXEL_BITS-1:0]               med;
  logic                                med_found;
  logic                                do_rep;
  logic [PIXEL_BITS-1:0]               res_pix;

  always_comb begin
    up_val = byp_r ? byp_data_r : up_q;

    // shift left by one column, new column on the right
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = up_val;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_q;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_pix_r;

    nb[0] = win_nxt[0];
    nb[1] = win_nxt[1];
    nb[2] = win_nxt[2];
    nb[3] = win_nxt[3];
    nb[4] = win_nxt[5];
    nb[5] = win_nxt[6];
    nb[6] = win_nxt[7];
    nb[7] = win_nxt[8];

    centre      = win_nxt[4];
    centre_dead = (centre == '0) || (centre == stuck);
    do_rep      = !s1_drain_r && s1_inner_r && centre_dead && med_found;

    if (s1_drain_r) begin
      res_pix = s1_selup_r ? up_val : mid_q;
    end else begin
      res_pix = do_rep ? med : centre;
    end
  end

  dpmc_median #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_median (
    .nb    (nb),
    .stuck (stuck),
    .med   (med),
    .found (med_found)
  );

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      pend_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      win_r       <= '0;
    end else begin
      if (accept) begin
        pend_r <= pend_nxt;
        if (!s0_drain) begin
          in_col_r <= in_col_nxt;
          in_row_r <= in_row_nxt;
        end
        if (s0_emit) begin
          out_col_r <= out_col_nxt;
          out_row_r <= out_row_nxt;
        end
      end
      if (adv) begin
        s1_valid_r  <= in_valid && s0_take;
        out_valid_r <= s1_valid_r && s1_emit_r;
      end
      // drain beats leave the window alone
      if (s1_leave && !s1_drain_r) begin
        win_r <= win_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register: hold while stalled
  // ---------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] out_pix_r;
  logic                  out_rep_r;
  logic                  out_fend_r;

  always_ff @(posedge clk) begin
    if (s1_leave && s1_emit_r) begin
      out_pix_r  <= res_pix;
      out_rep_r  <= do_rep;
      out_fend_r <= s1_fend_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_replaced  = out_rep_r;
  assign out_frame_end = out_fend_r;

endmodule

`default_nettype wire

/* src/dpmc_check.sv */
// Port-level checks for dead_pixel_median_correction, bound to the top level.
// Depends on the top level's port names only.
`default_nettype none

module dpmc_check #(
  parameter int PIXEL_BITS = 16
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [PIXEL_BITS-1:0] out_pixel_out,
  input wire logic                  out_replaced
);

  // back-pressure only comes from a waiting result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid)
    else $error("in_stall raised without a waiting result");

  // a replacement is a live neighbour, never the zero code
  a_rep_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_replaced |-> out_pixel_out != '0)
    else $error("replaced pixel carries the zero code");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind dead_pixel_median_correction dpmc_check #(
  .PIXEL_BITS (PIXEL_BITS)
) u_dpmc_check (.*);

`default_nettype wire
